// ===== hdl/led_mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// led_mfs_pkg
// Shared types and constants of the LED matrix frame buffer serializer.
// ----------------------------------------------------------------------------
package led_mfs_pkg;

    // geometry
    localparam int MODULE_COUNT_DEF = 4;
    localparam int ROW_COUNT        = 8;
    localparam int ROW_BITS         = 3;

    // function codes
    localparam logic [2:0] FUNC_OVERLAY  = 3'd0;
    localparam logic [2:0] FUNC_DRAW     = 3'd1;
    localparam logic [2:0] FUNC_CLEAR    = 3'd2;
    localparam logic [2:0] FUNC_REGWRITE = 3'd3;
    localparam logic [2:0] FUNC_BRIGHT   = 3'd4;

    // module register that holds the intensity
    localparam logic [7:0] INTENSITY_REG = 8'h0a;

    // one input request
    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] glyph_rows;
        logic [4:0]  bit_offset;
        logic [3:0]  reg_address;
        logic [7:0]  reg_value;
        logic [9:0]  level_sample;
    } t_in_item;

    // one shift word
    typedef struct packed {
        logic [15:0] shift_word;
        logic        latch_after;
        logic        last;
    } t_out_item;

endpackage

// ===== hdl/led_matrix_framebuffer_serializer_unit.sv =====
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_serializer_unit
// Frame store with glyph overlay and shift-word serializer for cascaded
// LED matrix modules.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on i_valid / i_data and are taken when o_stall is
//   low. Shift words leave on o_valid / o_data and are taken when i_stall is
//   low; a stalled word holds until taken.
//   The frame store sits in one synchronous RAM, one byte per row and module,
//   with a per-entry valid flag so that reset and clear take effect at once
//   (no clearing sweep).
//   One request is worked on at a time. A draw reads the RAM at one entry per
//   cycle while the queue has room and emits ROW_COUNT * MODULE_COUNT words; a
//   clear emits 8 * MODULE_COUNT words, a register write or brightness request
//   MODULE_COUNT words, one per cycle while the queue has room. An overlay
//   runs a read-modify-write over 2 * ROW_COUNT entries, one per cycle, and
//   emits nothing. Each word is registered after the RAM read and then in a
//   two-entry output queue; a stalled receiver pauses word generation through
//   the queue. The next request is accepted as soon as the previous one has
//   issued its last RAM access or word, while older words may still wait.
//   Reset empties the frame store, the queue and the sequencer.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_serializer_unit
    import led_mfs_pkg::*;
#(
    parameter int MODULE_COUNT = MODULE_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    localparam int MW    = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
    localparam int AW    = ROW_BITS + MW;
    localparam int DEPTH = ROW_COUNT << MW;
    localparam logic [MW-1:0] LAST_MOD = MW'(MODULE_COUNT - 1);
    localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(ROW_COUNT - 1);

    typedef enum logic [1:0] {
        K_OVERLAY,
        K_DRAW,
        K_CLEAR,
        K_BCAST
    } t_kind;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[7-b] = v[b];
        end
        return r;
    endfunction

    // sequencer state
    logic                r_busy;
    t_kind               r_kind;
    logic [ROW_BITS-1:0] r_row;
    logic [MW-1:0]       r_mod;
    logic                r_sub;
    logic [63:0]         r_glyph;
    logic [1:0]          r_sector;
    logic [2:0]          r_shift;
    logic [7:0]          r_baddr;
    logic [7:0]          r_bdata;

    // stage after the ram read
    logic          r_p_valid;
    logic          r_p_ovl;
    logic          r_p_mem;
    logic          r_p_we;
    logic [AW-1:0] r_p_addr;
    logic [7:0]    r_p_part;
    logic [7:0]    r_p_waddr;
    logic [7:0]    r_p_data;
    logic          r_p_latch;
    logic          r_p_last;

    // frame store
    logic [7:0]    r_mem [DEPTH];
    logic          r_vld [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_rd_vld;

    // output queue
    t_out_item     r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    logic          in_acc;
    logic          pop;
    logic [1:0]    occ;
    logic          credit;
    logic          step;
    logic          step_last;
    logic [7:0]    glyph_byte;
    logic [15:0]   spread;
    logic [3:0]    ovl_module;
    logic          ovl_we;
    logic [AW-1:0] ovl_addr;
    logic [AW-1:0] draw_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [7:0]    word_addr;
    logic [7:0]    word_data;
    logic [7:0]    rd_eff;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic          push;
    t_out_item     push_item;

    // handshakes
    assign in_acc  = i_valid && !r_busy;
    assign o_stall = r_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign pop     = o_valid && !i_stall;

    // words issued but not yet taken must fit in the queue
    assign occ    = r_cnt + 2'(r_p_valid && !r_p_ovl);
    assign credit = (occ < 2'd2) || pop;
    assign step   = r_busy && ((r_kind == K_OVERLAY) || credit);

    always_comb begin
        unique case (r_kind)
            K_OVERLAY: step_last = (r_row == LAST_ROW) && r_sub;
            K_DRAW:    step_last = (r_row == LAST_ROW) && (r_mod == LAST_MOD);
            K_CLEAR:   step_last = (r_row == LAST_ROW) && (r_mod == LAST_MOD);
            default:   step_last = (r_mod == LAST_MOD);
        endcase
    end

    // overlay: glyph byte split over the sector module and the next one
    assign glyph_byte = r_glyph[8*r_row +: 8];
    assign spread     = 16'(glyph_byte) << r_shift;
    assign ovl_module = 4'(r_sector) + 4'(r_sub);
    assign ovl_we     = (ovl_module < 4'(MODULE_COUNT)) && !(r_sub && (r_shift == 3'd0));
    assign ovl_addr   = {r_row, ovl_module[MW-1:0]};

    // draw walks modules from the far end of the chain
    assign draw_addr = {r_row, LAST_MOD - r_mod};
    assign rd_addr   = (r_kind == K_OVERLAY) ? ovl_addr : draw_addr;
    assign rd_en     = step && ((r_kind == K_OVERLAY) || (r_kind == K_DRAW));

    // address and data byte of the word being issued
    always_comb begin
        unique case (r_kind)
            K_DRAW: begin
                word_addr = 8'(4'd8 - {1'b0, r_row});
                word_data = 8'd0;
            end
            K_CLEAR: begin
                word_addr = 8'(r_row) + 8'd1;
                word_data = 8'd0;
            end
            default: begin
                word_addr = r_baddr;
                word_data = r_bdata;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_kind    <= K_OVERLAY;
            r_row     <= '0;
            r_mod     <= '0;
            r_sub     <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= step;
            if (in_acc) begin
                r_row    <= '0;
                r_mod    <= '0;
                r_sub    <= 1'b0;
                r_glyph  <= i_data.glyph_rows;
                r_sector <= i_data.bit_offset[4:3];
                r_shift  <= i_data.bit_offset[2:0];
                unique case (i_data.func)
                    FUNC_OVERLAY: begin
                        r_busy <= 1'b1;
                        r_kind <= K_OVERLAY;
                    end
                    FUNC_DRAW: begin
                        r_busy <= 1'b1;
                        r_kind <= K_DRAW;
                    end
                    FUNC_CLEAR: begin
                        r_busy <= 1'b1;
                        r_kind <= K_CLEAR;
                    end
                    FUNC_REGWRITE: begin
                        r_busy  <= 1'b1;
                        r_kind  <= K_BCAST;
                        r_baddr <= {4'd0, i_data.reg_address};
                        r_bdata <= i_data.reg_value;
                    end
                    FUNC_BRIGHT: begin
                        r_busy  <= 1'b1;
                        r_kind  <= K_BCAST;
                        r_baddr <= INTENSITY_REG;
                        r_bdata <= 8'(i_data.level_sample[9:6]);
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end else if (step) begin
                if (r_kind == K_OVERLAY) begin
                    r_sub <= !r_sub;
                    if (r_sub) begin
                        r_row <= r_row + 1'b1;
                    end
                end else if (r_mod == LAST_MOD) begin
                    r_mod <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_mod <= r_mod + 1'b1;
                end
                if (step_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_p_ovl   <= (r_kind == K_OVERLAY);
            r_p_mem   <= (r_kind == K_DRAW);
            r_p_we    <= ovl_we;
            r_p_addr  <= ovl_addr;
            r_p_part  <= r_sub ? spread[15:8] : spread[7:0];
            r_p_waddr <= word_addr;
            r_p_data  <= word_data;
            r_p_latch <= (r_mod == LAST_MOD);
            r_p_last  <= step_last;
        end
    end

    // read-modify-write of the frame store
    assign rd_eff  = r_rd_vld ? r_rd_data : 8'd0;
    assign wr_en   = r_p_valid && r_p_ovl && r_p_we;
    assign wr_data = rd_eff | r_p_part;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_p_addr] <= wr_data;
        end
    end

    // entry valid flags, cleared by reset and by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < DEPTH; e++) begin
                r_vld[e] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            if (wr_en) begin
                r_vld[r_p_addr] <= 1'b1;
            end
            if (in_acc && (i_data.func == FUNC_CLEAR)) begin
                for (int e = 0; e < DEPTH; e++) begin
                    r_vld[e] <= 1'b0;
                end
            end
        end
    end

    // output queue
    assign push = r_p_valid && !r_p_ovl;
    always_comb begin
        push_item.shift_word  = {r_p_waddr, r_p_mem ? rev8(rd_eff) : r_p_data};
        push_item.latch_after = r_p_latch;
        push_item.last        = r_p_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= push_item;
                r_wp      <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule
